[sv/tcg_pkg.sv]
// Shared types, constants and helpers for the text console character grid.
// Used by every module of the block; no dependencies.
package tcg_pkg;

  localparam int unsigned ROWS     = 24;
  localparam int unsigned COLUMNS  = 80;
  localparam int unsigned TAB_STOP = 4;
  localparam int unsigned CELLS    = ROWS * COLUMNS;

  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned TCNT_W = $clog2(TAB_STOP + 1);
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_EMPTY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [7:0] CODE_ZERO    = 8'h00;
  localparam logic [7:0] CODE_BS      = 8'h08;
  localparam logic [7:0] CODE_TAB     = 8'h09;
  localparam logic [7:0] CODE_LF      = 8'h0a;
  localparam logic [7:0] CODE_FF      = 8'h0c;
  localparam logic [7:0] CODE_CR      = 8'h0d;
  localparam logic [7:0] CODE_ESC     = 8'h1b;
  localparam logic [7:0] CODE_SPACE   = 8'h20;
  localparam logic [7:0] CODE_BRACKET = 8'h5b;

  typedef enum logic [3:0] {
    CLS_NOP,
    CLS_ZERO,
    CLS_GLYPH,
    CLS_BRACKET,
    CLS_ESC,
    CLS_LF,
    CLS_CR,
    CLS_BS,
    CLS_FF,
    CLS_TAB,
    CLS_READ,
    CLS_EMPTY
  } cls_e;

  typedef struct packed {
    cls_e              cls;
    logic [7:0]        code;
    logic [ROW_W-1:0]  rrow;
    logic [COL_W-1:0]  rcol;
    logic              last;
  } entry_t;

  // physical cell address of a logical row/column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] top);
    logic [ROW_W:0]   sum;
    logic [ROW_W-1:0] phys;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= (ROW_W + 1)'(ROWS)) begin
      sum = sum - (ROW_W + 1)'(ROWS);
    end
    phys = sum[ROW_W-1:0];
    return ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

[sv/tcg_queue.sv]
// Short entry queue between the front and back parts of the console grid.
// Depends on tcg_pkg.
module tcg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tcg_pkg::entry_t push_data_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output tcg_pkg::entry_t data_o
);

  tcg_pkg::entry_t                    mem_q [tcg_pkg::QDEPTH];
  logic [tcg_pkg::QPTR_W-1:0]         wptr_q, rptr_q;
  logic [tcg_pkg::QPTR_W:0]           cnt_q;

  assign ready_o = cnt_q != (tcg_pkg::QPTR_W + 1)'(tcg_pkg::QDEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i && ready_o) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i && valid_o) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if ((push_i && ready_o) && !(pop_i && valid_o)) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!(push_i && ready_o) && (pop_i && valid_o)) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[sv/tcg_front.sv]
// Front part: accepts input items, classifies them and queues entries.
// An end-of-message put adds a second newline entry. Depends on tcg_pkg.
module tcg_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [1:0]                op_i,
  input  logic [7:0]                char_code_i,
  input  logic                      end_of_message_i,
  input  logic [tcg_pkg::ROW_W-1:0] read_row_i,
  input  logic [tcg_pkg::COL_W-1:0] read_column_i,
  input  logic                      back_ready_i,
  output logic                      push_o,
  output tcg_pkg::entry_t           push_data_o,
  input  logic                      q_ready_i
);

  logic          lf_pend_q, lf_pend_d;
  logic          accept;
  tcg_pkg::cls_e cls;

  assign ready_o = !lf_pend_q && q_ready_i && back_ready_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    unique case (op_i)
      tcg_pkg::OP_PUT: begin
        unique case (char_code_i)
          tcg_pkg::CODE_ZERO:    cls = tcg_pkg::CLS_ZERO;
          tcg_pkg::CODE_LF:      cls = tcg_pkg::CLS_LF;
          tcg_pkg::CODE_CR:      cls = tcg_pkg::CLS_CR;
          tcg_pkg::CODE_BS:      cls = tcg_pkg::CLS_BS;
          tcg_pkg::CODE_FF:      cls = tcg_pkg::CLS_FF;
          tcg_pkg::CODE_TAB:     cls = tcg_pkg::CLS_TAB;
          tcg_pkg::CODE_ESC:     cls = tcg_pkg::CLS_ESC;
          tcg_pkg::CODE_BRACKET: cls = tcg_pkg::CLS_BRACKET;
          default:               cls = tcg_pkg::CLS_GLYPH;
        endcase
      end
      tcg_pkg::OP_READ:  cls = tcg_pkg::CLS_READ;
      tcg_pkg::OP_EMPTY: cls = tcg_pkg::CLS_EMPTY;
      default:           cls = tcg_pkg::CLS_NOP;
    endcase
  end

  always_comb begin
    lf_pend_d   = lf_pend_q;
    push_o      = 1'b0;
    push_data_o = '{cls: cls, code: char_code_i, rrow: read_row_i,
                    rcol: read_column_i, last: 1'b1};
    if (lf_pend_q) begin
      if (q_ready_i) begin
        push_o           = 1'b1;
        push_data_o.cls  = tcg_pkg::CLS_LF;
        push_data_o.code = tcg_pkg::CODE_LF;
        lf_pend_d        = 1'b0;
      end
    end else if (accept) begin
      push_o = 1'b1;
      if (op_i == tcg_pkg::OP_PUT && end_of_message_i) begin
        push_data_o.last = 1'b0;
        lf_pend_d        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lf_pend_q <= 1'b0;
    end else begin
      lf_pend_q <= lf_pend_d;
    end
  end

endmodule

[sv/tcg_back.sv]
// Back part: executes queued entries on the cell memory, owns cursor,
// scroll offset, escape state and the result register. Depends on tcg_pkg.
module tcg_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  tcg_pkg::entry_t           q_data_i,
  output logic                      pop_o,
  output logic                      ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                cell_data_o,
  output logic [tcg_pkg::ROW_W-1:0] cursor_row_now_o,
  output logic [tcg_pkg::COL_W-1:0] cursor_column_now_o
);

  localparam int unsigned ROW_W  = tcg_pkg::ROW_W;
  localparam int unsigned COL_W  = tcg_pkg::COL_W;
  localparam int unsigned ADDR_W = tcg_pkg::ADDR_W;
  localparam int unsigned TCNT_W = tcg_pkg::TCNT_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_GLYPH = 7'b0000100,
    S_TAB   = 7'b0001000,
    S_CLR   = 7'b0010000,
    S_READ  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  logic [7:0] mem [tcg_pkg::CELLS];
  logic [7:0] mem_rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  state_e            state_q, state_d, gret_q, gret_d, cret_q, cret_d, nxt;
  tcg_pkg::entry_t   cur_q, cur_d;
  logic [ROW_W-1:0]  row_q, row_d, top_q, top_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              esc_q, esc_d, init_q, init_d, rd_ok_q, rd_ok_d;
  logic [7:0]        gv_q, gv_d, rcell_q, rcell_d;
  logic [TCNT_W-1:0] tcnt_q, tcnt_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d, clr_end_q, clr_end_d;
  logic              ov_q, ov_d;
  logic [7:0]        ocell_q, ocell_d;
  logic [ROW_W-1:0]  orow_q, orow_d;
  logic [COL_W-1:0]  ocol_q, ocol_d;

  logic              wr_cell, nrow, frow, rd_ok, in_edge;
  logic [7:0]        wr_val;
  logic [ADDR_W-1:0] top_base;

  assign ready_o             = !init_q;
  assign out_valid_o         = ov_q;
  assign cell_data_o         = ocell_q;
  assign cursor_row_now_o    = orow_q;
  assign cursor_column_now_o = ocol_q;

  assign in_edge  = col_q < COL_W'(tcg_pkg::COLUMNS);
  assign top_base = ADDR_W'(top_q) * ADDR_W'(tcg_pkg::COLUMNS);
  assign rd_ok    = cur_q.rrow < ROW_W'(tcg_pkg::ROWS) && cur_q.rcol < COL_W'(tcg_pkg::COLUMNS);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  always_comb begin
    state_d    = state_q;
    gret_d     = gret_q;
    cret_d     = cret_q;
    cur_d      = cur_q;
    row_d      = row_q;
    col_d      = col_q;
    top_d      = top_q;
    esc_d      = esc_q;
    init_d     = init_q;
    rd_ok_d    = rd_ok_q;
    gv_d       = gv_q;
    rcell_d    = rcell_q;
    tcnt_d     = tcnt_q;
    clr_addr_d = clr_addr_q;
    clr_end_d  = clr_end_q;
    ov_d       = ov_q && !out_ready_i;
    ocell_d    = ocell_q;
    orow_d     = orow_q;
    ocol_d     = ocol_q;
    pop_o      = 1'b0;
    wr_cell    = 1'b0;
    wr_val     = '0;
    nrow       = 1'b0;
    frow       = 1'b0;
    nxt        = state_q;
    mem_we     = 1'b0;
    mem_waddr  = tcg_pkg::cell_addr(row_q, col_q, top_q);
    mem_wdata  = '0;
    mem_raddr  = rd_ok ? tcg_pkg::cell_addr(cur_q.rrow, cur_q.rcol, top_q) : '0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          cur_d   = q_data_i;
          rcell_d = '0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (esc_q && cur_q.cls != tcg_pkg::CLS_NOP && cur_q.cls != tcg_pkg::CLS_READ
            && cur_q.cls != tcg_pkg::CLS_EMPTY) begin
          // held ESC: dropped with '[', otherwise emitted as a glyph first
          esc_d = 1'b0;
          if (cur_q.cls == tcg_pkg::CLS_BRACKET) begin
            state_d = S_DONE;
          end else begin
            gv_d    = tcg_pkg::CODE_ESC;
            gret_d  = S_EXEC;
            state_d = S_GLYPH;
          end
        end else begin
          case (cur_q.cls)
            tcg_pkg::CLS_GLYPH, tcg_pkg::CLS_BRACKET: begin
              gv_d    = cur_q.code;
              gret_d  = S_DONE;
              state_d = S_GLYPH;
            end
            tcg_pkg::CLS_LF: begin
              wr_cell = 1'b1;
              nrow    = 1'b1;
              nxt     = S_DONE;
            end
            tcg_pkg::CLS_CR: begin
              wr_cell = 1'b1;
              col_d   = '0;
              state_d = S_DONE;
            end
            tcg_pkg::CLS_BS: begin
              wr_cell = 1'b1;
              if (col_q != '0) begin
                col_d = col_q - 1'b1;
              end
              state_d = S_DONE;
            end
            tcg_pkg::CLS_FF: begin
              wr_cell = 1'b1;
              frow    = 1'b1;
              nxt     = S_DONE;
            end
            tcg_pkg::CLS_TAB: begin
              // the first space overwrites the cleared cursor cell
              tcnt_d  = TCNT_W'(tcg_pkg::TAB_STOP) - TCNT_W'(col_q % tcg_pkg::TAB_STOP);
              state_d = S_TAB;
            end
            tcg_pkg::CLS_ESC: begin
              esc_d   = 1'b1;
              state_d = S_DONE;
            end
            tcg_pkg::CLS_READ: begin
              rd_ok_d = rd_ok;
              state_d = S_READ;
            end
            tcg_pkg::CLS_EMPTY: begin
              clr_addr_d = '0;
              clr_end_d  = ADDR_W'(tcg_pkg::CELLS - 1);
              cret_d     = S_DONE;
              state_d    = S_CLR;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_GLYPH: begin
        if (!in_edge) begin
          nrow = 1'b1;
          nxt  = S_GLYPH;
        end else begin
          wr_cell = 1'b1;
          wr_val  = gv_q;
          col_d   = col_q + 1'b1;
          nrow    = (col_q + 1'b1) == COL_W'(tcg_pkg::COLUMNS);
          nxt     = gret_q;
          state_d = gret_q;
        end
      end
      S_TAB: begin
        if (tcnt_q != '0 && in_edge) begin
          wr_cell = 1'b1;
          wr_val  = tcg_pkg::CODE_SPACE;
          col_d   = col_q + 1'b1;
          tcnt_d  = tcnt_q - 1'b1;
        end else begin
          wr_cell = 1'b1;
          state_d = S_DONE;
        end
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        if (clr_addr_q == clr_end_q) begin
          init_d  = 1'b0;
          state_d = cret_q;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end
      S_READ: begin
        rcell_d = rd_ok_q ? mem_rdata_q : '0;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!cur_q.last) begin
          state_d = S_IDLE;
        end else if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ocell_d = rcell_q;
          orow_d  = row_q;
          ocol_d  = col_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (wr_cell && in_edge) begin
      mem_we    = 1'b1;
      mem_wdata = wr_val;
    end

    // row advance, with scroll and clear of the row that comes free
    if (nrow || frow) begin
      if (nrow) begin
        col_d = '0;
      end
      if (row_q == ROW_W'(tcg_pkg::ROWS - 1)) begin
        clr_addr_d = top_base;
        clr_end_d  = top_base + ADDR_W'(tcg_pkg::COLUMNS - 1);
        top_d      = (top_q == ROW_W'(tcg_pkg::ROWS - 1)) ? '0 : top_q + 1'b1;
        cret_d     = nxt;
        state_d    = S_CLR;
      end else begin
        row_d   = row_q + 1'b1;
        state_d = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      cret_q     <= S_IDLE;
      gret_q     <= S_DONE;
      row_q      <= '0;
      col_q      <= '0;
      top_q      <= '0;
      esc_q      <= 1'b0;
      init_q     <= 1'b1;
      tcnt_q     <= '0;
      clr_addr_q <= '0;
      clr_end_q  <= ADDR_W'(tcg_pkg::CELLS - 1);
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      cret_q     <= cret_d;
      gret_q     <= gret_d;
      row_q      <= row_d;
      col_q      <= col_d;
      top_q      <= top_d;
      esc_q      <= esc_d;
      init_q     <= init_d;
      tcnt_q     <= tcnt_d;
      clr_addr_q <= clr_addr_d;
      clr_end_q  <= clr_end_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    rd_ok_q <= rd_ok_d;
    gv_q    <= gv_d;
    rcell_q <= rcell_d;
    ocell_q <= ocell_d;
    orow_q  <= orow_d;
    ocol_q  <= ocol_d;
  end

endmodule

[sv/text_console_character_grid_core.sv]
// Top level of the text console character grid: stream ports around the
// front, the entry queue and the back. Depends on tcg_pkg and its modules.
//
// Usage: each item on the s_axis channel is one operation (put a character,
// read a cell, empty the screen); each item gives exactly one result on the
// m_axis channel, with the read cell (0 for other ops) and the cursor.
// tlast on input appends a newline after the character of a put.
// Throughput is set by the back sequencer, which takes one entry at a time
// and makes at most one memory write a cycle: a tab writes one space per
// cell it passes, a held ESC written out as a glyph adds a glyph step, a
// scroll clears the 80 cells of the freed row and emptying clears all 1920.
// tlast adds the appended newline as a second entry for the back.
// A four-entry queue lets the front accept items while the back works.
// Reset: the cursor, scroll offset and escape state clear at once; then a
// clearing pass over all 1920 cells zeroes the cell memory, with s_axis_tready
// low all that time.
// A stalled receiver holds the result in the output register; the queue
// keeps filling until full, then s_axis_tready drops.
module text_console_character_grid_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] char_code, [12:8] read_row, [19:13] read_column, [23:20] zero
  input  logic [23:0] s_axis_tdata_i,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] cell_data, [12:8] cursor_row_now, [19:13] cursor_column_now, [23:20] zero
  output logic [23:0] m_axis_tdata_o
);

  logic            push, q_ready, pop, q_valid, back_ready;
  tcg_pkg::entry_t push_data, q_data;
  logic [7:0]                cell_data;
  logic [tcg_pkg::ROW_W-1:0] cur_row;
  logic [tcg_pkg::COL_W-1:0] cur_col;

  tcg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (s_axis_tvalid_i),
    .ready_o         (s_axis_tready_o),
    .op_i            (s_axis_tuser_i),
    .char_code_i     (s_axis_tdata_i[7:0]),
    .end_of_message_i(s_axis_tlast_i),
    .read_row_i      (s_axis_tdata_i[12:8]),
    .read_column_i   (s_axis_tdata_i[19:13]),
    .back_ready_i    (back_ready),
    .push_o          (push),
    .push_data_o     (push_data),
    .q_ready_i       (q_ready)
  );

  tcg_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .ready_o    (q_ready),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .data_o     (q_data)
  );

  tcg_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_data_i           (q_data),
    .pop_o              (pop),
    .ready_o            (back_ready),
    .out_valid_o        (m_axis_tvalid_o),
    .out_ready_i        (m_axis_tready_i),
    .cell_data_o        (cell_data),
    .cursor_row_now_o   (cur_row),
    .cursor_column_now_o(cur_col)
  );

  assign m_axis_tdata_o = {4'd0, cur_col, cur_row, cell_data};

endmodule
